### rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and default sizes for the counting semaphore table.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    // default table sizes
    localparam int unsigned DEF_SEMAPHORES = 16;
    localparam int unsigned DEF_TASK_SLOTS = 16;
    localparam int unsigned DEF_COUNT_BITS = 16;

    // waiter memory: semaphore index bits plus queue position bits
    localparam int unsigned DEF_WAITER_ADDR_W = 8;

    // fixed field widths of the request and response
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned SEM_IDX_W = 5;
    localparam int unsigned INIT_W    = 16;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned STATUS_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT    = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_SIGNAL  = 2'd2,
        MODE_DESTROY = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2,
        ST_DENIED  = 2'd3
    } status_t;

    // waiter memory strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } waiter_ctl_t;

endpackage

`default_nettype wire

### rtl/core/cst_req_if.sv
// ----------------------------------------------------------------------------
// cst_req_if
// Request channel of the semaphore table: valid/ready plus request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_req_if import cst_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [SEM_IDX_W-1:0] semaphore_index;
    logic [INIT_W-1:0]    initial_count;
    logic [SLOT_W-1:0]    caller_slot;
    logic                 caller_is_process_zero;

    modport source (
        output valid, mode, semaphore_index, initial_count, caller_slot,
               caller_is_process_zero,
        input  ready
    );

    modport sink (
        input  valid, mode, semaphore_index, initial_count, caller_slot,
               caller_is_process_zero,
        output ready
    );

endinterface

`default_nettype wire

### rtl/core/cst_rsp_if.sv
// ----------------------------------------------------------------------------
// cst_rsp_if
// Response channel of the semaphore table: valid/ready plus result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_rsp_if import cst_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                caller_blocked;
    logic                woken_valid;
    logic [SLOT_W-1:0]   woken_slot;

    modport source (
        output valid, status, caller_blocked, woken_valid, woken_slot,
        input  ready
    );

    modport sink (
        input  valid, status, caller_blocked, woken_valid, woken_slot,
        output ready
    );

endinterface

`default_nettype wire

### rtl/core/cst_waiter_ram.sv
// ----------------------------------------------------------------------------
// cst_waiter_ram
// Single-port store of queued task slots, one row of queue positions per
// semaphore, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_waiter_ram import cst_pkg::*; #(
    parameter int unsigned ADDR_W = DEF_WAITER_ADDR_W
) (
    input  logic              clk,
    input  waiter_ctl_t       ctl,
    input  logic [ADDR_W-1:0] addr,
    input  logic [SLOT_W-1:0] wr_data,
    output logic [SLOT_W-1:0] rd_data
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [SLOT_W-1:0] mem [DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/counting_semaphore_table_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit
// Table of counting semaphores, each with a FIFO queue of blocked task slots.
// ----------------------------------------------------------------------------
// Requests arrive on req (init, wait, signal or destroy of one semaphore) and
// each gives exactly one transaction on rsp with status, caller_blocked,
// woken_valid and woken_slot.
// A request is taken into an input register, handled there against the
// flop-based per-semaphore state (flag, count, queue head and fill) and the
// waiter memory, and lands in the result register that drives rsp.valid;
// one request is taken per cycle as long as rsp is not stalled.
// The single waiter memory port does either the enqueue write of a blocking
// wait or the dequeue read of a signal, so no request needs two accesses.
// When rsp is stalled the result register and the memory read data hold, and
// req stays ready until the input register is also full.
// Reset clears every semaphore (not initialized, count zero, queue empty);
// the waiter memory needs no clearing since only queued entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table_unit import cst_pkg::*; #(
    parameter int unsigned SEMAPHORES = DEF_SEMAPHORES,
    parameter int unsigned TASK_SLOTS = DEF_TASK_SLOTS,
    parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    cst_req_if.sink   req,
    cst_rsp_if.source rsp
);

    localparam int unsigned IDX_W  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam int unsigned HEAD_W = $clog2(TASK_SLOTS);
    localparam int unsigned FILL_W = $clog2(TASK_SLOTS + 1);
    localparam int unsigned ADDR_W = IDX_W + HEAD_W;
    localparam int unsigned LIM_W  = SEM_IDX_W + 1;
    localparam int unsigned EXT_W  = 32;

    localparam logic [LIM_W-1:0]      SEM_LIMIT  = LIM_W'(SEMAPHORES);
    localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(TASK_SLOTS);
    localparam logic [HEAD_W-1:0]     HEAD_LAST  = HEAD_W'(TASK_SLOTS - 1);
    localparam logic [HEAD_W:0]       SLOTS_EXT  = (HEAD_W + 1)'(TASK_SLOTS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // input register
    logic                 s1_valid_reg;
    mode_t                s1_mode_reg;
    logic [SEM_IDX_W-1:0] s1_index_reg;
    logic [INIT_W-1:0]    s1_count_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;
    logic                 s1_pzero_reg;

    // per-semaphore state
    logic [SEMAPHORES-1:0] init_reg;
    logic [COUNT_BITS-1:0] count_reg [SEMAPHORES];
    logic [HEAD_W-1:0]     head_reg  [SEMAPHORES];
    logic [FILL_W-1:0]     fill_reg  [SEMAPHORES];

    // result register
    logic    out_valid_reg;
    status_t out_status_reg;
    logic    out_blocked_reg;
    logic    out_wvalid_reg;

    logic              advance;
    logic              s1_fire;
    logic              in_range;
    logic [IDX_W-1:0]  sel_idx;
    logic              cur_init;
    logic [COUNT_BITS-1:0] cur_count;
    logic [HEAD_W-1:0] cur_head;
    logic [FILL_W-1:0] cur_fill;
    logic [HEAD_W:0]   tail_sum;
    logic [HEAD_W:0]   tail_wrap;
    logic [HEAD_W-1:0] tail_pos;
    logic [HEAD_W-1:0] head_inc;
    logic [EXT_W-1:0]  init_ext;

    status_t           status_next;
    logic              blocked_next;
    logic              wvalid_next;
    logic              init_next;
    logic [COUNT_BITS-1:0] count_next;
    logic [HEAD_W-1:0] head_next;
    logic [FILL_W-1:0] fill_next;
    waiter_ctl_t       mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    logic [SLOT_W-1:0] mem_rd_data;

    assign advance   = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_mode_reg  <= mode_t'(req.mode);
            s1_index_reg <= req.semaphore_index;
            s1_count_reg <= req.initial_count;
            s1_slot_reg  <= req.caller_slot;
            s1_pzero_reg <= req.caller_is_process_zero;
        end
    end

    // ------------------------------------------------------------------
    // selected semaphore and queue arithmetic
    // ------------------------------------------------------------------
    assign in_range  = {1'b0, s1_index_reg} < SEM_LIMIT;
    assign sel_idx   = in_range ? s1_index_reg[IDX_W-1:0] : '0;
    assign cur_init  = init_reg[sel_idx];
    assign cur_count = count_reg[sel_idx];
    assign cur_head  = head_reg[sel_idx];
    assign cur_fill  = fill_reg[sel_idx];

    // tail position is head plus fill, wrapped once
    assign tail_sum  = (HEAD_W + 1)'(cur_head) + (HEAD_W + 1)'(cur_fill);
    assign tail_wrap = (tail_sum >= SLOTS_EXT) ? (tail_sum - SLOTS_EXT) : tail_sum;
    assign tail_pos  = tail_wrap[HEAD_W-1:0];
    assign head_inc  = (cur_head == HEAD_LAST) ? '0 : cur_head + 1'b1;
    assign init_ext  = EXT_W'(s1_count_reg);

    always_comb
    begin
        status_next    = ST_OK;
        blocked_next   = 1'b0;
        wvalid_next    = 1'b0;
        init_next      = cur_init;
        count_next     = cur_count;
        head_next      = cur_head;
        fill_next      = cur_fill;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.rd_en  = 1'b0;
        mem_addr       = {sel_idx, cur_head};

        if (!in_range)
        begin
            status_next = ST_INVALID;
        end
        else if (s1_mode_reg == MODE_INIT)
        begin
            if (cur_init)
            begin
                status_next = ST_BUSY;
            end
            else
            begin
                init_next  = 1'b1;
                count_next = init_ext[COUNT_BITS-1:0];
                head_next  = '0;
                fill_next  = '0;
            end
        end
        else if (!cur_init)
        begin
            status_next = ST_INVALID;
        end
        else
        begin
            unique case (s1_mode_reg)
                MODE_WAIT:
                begin
                    if (s1_pzero_reg)
                    begin
                        status_next = ST_DENIED;
                    end
                    else if (cur_count != '0)
                    begin
                        count_next = cur_count - 1'b1;
                    end
                    else if (cur_fill >= FILL_FULL)
                    begin
                        status_next = ST_DENIED;
                    end
                    else
                    begin
                        mem_ctl.wr_en = s1_fire;
                        mem_addr      = {sel_idx, tail_pos};
                        fill_next     = cur_fill + 1'b1;
                        blocked_next  = 1'b1;
                    end
                end
                MODE_SIGNAL:
                begin
                    if (cur_fill != '0)
                    begin
                        mem_ctl.rd_en = s1_fire;
                        wvalid_next   = 1'b1;
                        head_next     = head_inc;
                        fill_next     = cur_fill - 1'b1;
                    end
                    else if (cur_count != COUNT_MAX)
                    begin
                        count_next = cur_count + 1'b1;
                    end
                end
                MODE_DESTROY:
                begin
                    if (cur_fill != '0)
                    begin
                        status_next = ST_BUSY;
                    end
                    else
                    begin
                        init_next = 1'b0;
                    end
                end
                default:
                begin
                    // init is handled above
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // semaphore state update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
            for (int i = 0; i < SEMAPHORES; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else if (s1_fire && in_range)
        begin
            init_reg[sel_idx]  <= init_next;
            count_reg[sel_idx] <= count_next;
            head_reg[sel_idx]  <= head_next;
            fill_reg[sel_idx]  <= fill_next;
        end
    end

    cst_waiter_ram #(
        .ADDR_W (ADDR_W)
    ) u_waiter_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (s1_slot_reg),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_status_reg  <= status_next;
            out_blocked_reg <= blocked_next;
            out_wvalid_reg  <= wvalid_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.caller_blocked = out_blocked_reg;
    assign rsp.woken_valid    = out_wvalid_reg;
    // read data only updates on a wake, so mask it otherwise
    assign rsp.woken_slot     = out_wvalid_reg ? mem_rd_data : '0;

endmodule

`default_nettype wire
